// ===== sv/swpr_pkg.sv =====
// ----------------------------------------------------------------------------
// swpr_pkg
// Shared types and codes for the stack with parity removal.
// ----------------------------------------------------------------------------
package swpr_pkg;

    localparam logic [1:0] ACT_PUSH     = 2'd0;
    localparam logic [1:0] ACT_POP      = 2'd1;
    localparam logic [1:0] ACT_POP_ODD  = 2'd2;
    localparam logic [1:0] ACT_POP_EVEN = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    typedef struct packed {
        logic push_en;
        logic pop_en;
        logic scan_en;
        logic want_odd;
    } t_cell_ctl;

endpackage

// ===== sv/swpr_cell.sv =====
// ----------------------------------------------------------------------------
// swpr_cell
// One stack entry: holds a word, shifts up or down with its neighbours and
// passes the topmost-match flag towards the bottom of the chain.
// ----------------------------------------------------------------------------
module swpr_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   i_clk,
    input  swpr_pkg::t_cell_ctl    i_ctl,
    input  logic                   i_live,
    input  logic [DATA_WIDTH-1:0]  i_above,
    input  logic [DATA_WIDTH-1:0]  i_below,
    input  logic                   i_found,
    output logic                   o_found,
    output logic [DATA_WIDTH-1:0]  o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_match;

    assign w_match = i_live & (r_data[0] == i_ctl.want_odd);
    assign o_found = i_found | w_match;
    assign o_data  = r_data;

    always_comb begin
        if (i_ctl.push_en) begin
            n_data = i_above;
        end else if (i_ctl.pop_en || (i_ctl.scan_en && o_found)) begin
            n_data = i_below;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== sv/stack_with_parity_removal.sv =====
// ----------------------------------------------------------------------------
// stack_with_parity_removal
// Bounded LIFO of signed words with pop, pop-topmost-odd and pop-topmost-even.
// ----------------------------------------------------------------------------
// Each transaction takes one clock cycle: busy never rises, so start may be
// held high every cycle, and the result appears on the o_ ports with o_strobe
// in the cycle after acceptance. This rests on the cell chain: cell 0
// holds the top entry, every cell compares its own parity at once and the
// match flag ripples combinationally through all DEPTH cells, after
// which the matching cell and those below it take their lower neighbour.
// Results cannot be held off; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module stack_with_parity_removal #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_push_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_top_value,
    output logic               o_is_empty,
    output logic [6:0]         o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                  w_accept;
    swpr_pkg::t_cell_ctl   w_ctl;
    logic [DEPTH:0]        w_found;
    logic [DEPTH-1:0]      w_live;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_push_word;
    logic                  w_hit;

    logic                  r_strobe;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;

    assign busy        = 1'b0;
    assign w_accept    = start & ~busy;
    assign w_push_word = DATA_WIDTH'(i_push_value);
    assign w_found[0]  = 1'b0;
    assign w_hit       = w_found[DEPTH];

    always_comb begin
        w_ctl          = '0;
        w_ctl.want_odd = (i_action == swpr_pkg::ACT_POP_ODD);
        if (w_accept) begin
            unique case (i_action) inside
                swpr_pkg::ACT_PUSH: begin
                    w_ctl.push_en = (r_count != CW'(DEPTH));
                end
                swpr_pkg::ACT_POP: begin
                    w_ctl.pop_en = (r_count != '0);
                end
                swpr_pkg::ACT_POP_ODD, swpr_pkg::ACT_POP_EVEN: begin
                    w_ctl.scan_en = (r_count != '0);
                end
                default: begin
                    w_ctl.scan_en = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_status = swpr_pkg::STATUS_OK;
        n_count  = r_count;
        if (w_accept) begin
            unique case (i_action) inside
                swpr_pkg::ACT_PUSH: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = swpr_pkg::STATUS_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                swpr_pkg::ACT_POP: begin
                    if (r_count == '0) begin
                        n_status = swpr_pkg::STATUS_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                swpr_pkg::ACT_POP_ODD, swpr_pkg::ACT_POP_EVEN: begin
                    if (r_count == '0) begin
                        n_status = swpr_pkg::STATUS_EMPTY;
                    end else if (w_hit) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = swpr_pkg::STATUS_NO_MATCH;
                    end
                end
                default: begin
                    n_status = swpr_pkg::STATUS_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_live[g] = (CW'(g) < r_count);

        swpr_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_live  (w_live[g]),
            .i_above ((g == 0) ? w_push_word : w_data[(g == 0) ? 0 : g - 1]),
            .i_below ((g == DEPTH - 1) ? '0 : w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_status <= swpr_pkg::STATUS_OK;
            r_count  <= '0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_status <= n_status;
                r_count  <= n_count;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_is_empty    = (r_count == '0);
    assign o_entry_count = 7'(r_count);
    assign o_top_value   = (r_count == '0) ? 32'sd0 : 32'($signed(w_data[0]));

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == swpr_pkg::ACT_PUSH && r_count != CW'(DEPTH))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

    a_empty_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == swpr_pkg::STATUS_EMPTY) |-> (r_count == '0))
        else $error("empty status on a non-empty stack");

    a_no_match_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.scan_en && !w_hit) |=> (r_count == $past(r_count)
        && o_status == swpr_pkg::STATUS_NO_MATCH))
        else $error("failed parity search changed the stack");

    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == swpr_pkg::STATUS_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status below depth");
`endif

endmodule

// ===== tb/stack_with_parity_removal_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_with_parity_removal_test
// Self-checking testbench for the stack with parity removal.
// ----------------------------------------------------------------------------
// A shadow copy of the stack predicts the result of every accepted
// transaction: push, pop, removal of the topmost odd or even word, and the
// empty, no-match and full-push cases. Each strobed result is compared field
// by field with the oldest prediction. Directed tests cover the empty stack,
// extreme and negative words and in-stack removal. Random tests fill and
// drain the store and mix actions with varying push bias. Start gaps are
// inserted at random, apart from one long stretch.
// ----------------------------------------------------------------------------
module stack_with_parity_removal_test;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] top_value;
        logic               is_empty;
        logic [6:0]         entry_count;
    } t_stack_view;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_action;
    logic signed [31:0] i_push_value;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic signed [31:0] o_top_value;
    logic               o_is_empty;
    logic [6:0]         o_entry_count;

    logic [31:0]  shadow_words [STACK_DEPTH];
    int           shadow_fill;
    t_stack_view  expected_views[$];
    int           failures;
    int           cycle_count;
    int           gap_pct;

    stack_with_parity_removal #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_push_value  (i_push_value),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_is_empty    (o_is_empty),
        .o_entry_count (o_entry_count)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_stack_view apply_action(input logic [1:0] act,
                                                 input logic [31:0] word);
        t_stack_view view;
        int          pos;
        logic        want_odd;
        view.status = swpr_pkg::STATUS_OK;
        if (act == swpr_pkg::ACT_PUSH) begin
            if (shadow_fill == STACK_DEPTH) begin
                view.status = swpr_pkg::STATUS_FULL;
            end else begin
                shadow_words[shadow_fill] = word;
                shadow_fill++;
            end
        end else if (shadow_fill == 0) begin
            view.status = swpr_pkg::STATUS_EMPTY;
        end else if (act == swpr_pkg::ACT_POP) begin
            shadow_fill--;
        end else begin
            want_odd = (act == swpr_pkg::ACT_POP_ODD);
            pos = shadow_fill - 1;
            while (pos >= 0 && shadow_words[pos][0] != want_odd)
                pos--;
            if (pos < 0) begin
                view.status = swpr_pkg::STATUS_NO_MATCH;
            end else begin
                for (int i = pos; i < shadow_fill - 1; i++)
                    shadow_words[i] = shadow_words[i + 1];
                shadow_fill--;
            end
        end
        view.top_value   = (shadow_fill != 0) ? shadow_words[shadow_fill - 1] : 32'sd0;
        view.is_empty    = (shadow_fill == 0);
        view.entry_count = shadow_fill[6:0];
        return view;
    endfunction

    // Hold start low for a random gap, then present one transaction.
    task automatic send_action(input logic [1:0] act, input logic [31:0] word);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct)
            gap = 1;
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_action     <= act;
        i_push_value <= word;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        expected_views.push_back(apply_action(act, word));
    endtask

    function automatic logic [31:0] pick_word(input int parity_bias);
        logic [31:0] word;
        case ($urandom_range(9))
            0: word = 32'h8000_0000;
            1: word = 32'h7FFF_FFFF;
            2: word = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: word = $urandom;
        endcase
        if (parity_bias == 1)
            word[0] = 1'b1;
        else if (parity_bias == 2)
            word[0] = 1'b0;
        return word;
    endfunction

    function automatic logic [1:0] pick_removal();
        case ($urandom_range(2))
            0: return swpr_pkg::ACT_POP;
            1: return swpr_pkg::ACT_POP_ODD;
            default: return swpr_pkg::ACT_POP_EVEN;
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        t_stack_view want;
        if (i_rst_n && o_strobe) begin
            if (expected_views.size() == 0) begin
                $error("result strobed with no transaction outstanding");
                failures++;
            end else begin
                want = expected_views.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    failures++;
                end
                if (o_top_value !== want.top_value) begin
                    $error("top_value: expected %0d, got %0d", want.top_value, o_top_value);
                    failures++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                    failures++;
                end
                if (o_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_entry_count);
                    failures++;
                end
            end
        end
    end

    task automatic test_empty_stack();
        send_action(swpr_pkg::ACT_POP, $urandom);
        send_action(swpr_pkg::ACT_POP_ODD, $urandom);
        send_action(swpr_pkg::ACT_POP_EVEN, $urandom);
    endtask

    // Extreme and negative words; removal from the middle and the bottom.
    task automatic test_parity_removal();
        send_action(swpr_pkg::ACT_PUSH, 32'h8000_0000);
        send_action(swpr_pkg::ACT_PUSH, 32'h7FFF_FFFF);
        send_action(swpr_pkg::ACT_PUSH, 32'h0000_0000);
        send_action(swpr_pkg::ACT_PUSH, 32'hFFFF_FFFF);
        send_action(swpr_pkg::ACT_PUSH, 32'hFFFF_FFFD);
        send_action(swpr_pkg::ACT_PUSH, 32'hFFFF_FFFC);
        send_action(swpr_pkg::ACT_POP_ODD, 32'hFFFF_FFFF);
        send_action(swpr_pkg::ACT_POP_EVEN, 32'h0000_0000);
        send_action(swpr_pkg::ACT_POP_EVEN, $urandom);
        send_action(swpr_pkg::ACT_POP_EVEN, $urandom);
        send_action(swpr_pkg::ACT_POP_EVEN, $urandom);
        send_action(swpr_pkg::ACT_POP_ODD, $urandom);
        send_action(swpr_pkg::ACT_POP, $urandom);
        send_action(swpr_pkg::ACT_POP_ODD, $urandom);
    endtask

    // Fill to the limit, push past it, then drain to empty and beyond.
    task automatic test_fill_and_drain(input int parity_bias);
        int extra;
        while (shadow_fill < STACK_DEPTH)
            send_action(swpr_pkg::ACT_PUSH, pick_word(parity_bias));
        extra = $urandom_range(1, 3);
        repeat (extra) send_action(swpr_pkg::ACT_PUSH, pick_word(0));
        while (shadow_fill > 0)
            send_action(pick_removal(), $urandom);
        extra = $urandom_range(1, 3);
        repeat (extra) send_action(pick_removal(), $urandom);
    endtask

    task automatic test_random_mix(input int count);
        int push_pct;
        int parity_bias;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                case ($urandom_range(2))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
                parity_bias = $urandom_range(3) == 0 ? $urandom_range(1, 2) : 0;
            end
            gap_pct = (n >= count / 3 && n < count / 2) ? 0 : 17;
            if ($urandom_range(99) < push_pct)
                send_action(swpr_pkg::ACT_PUSH, pick_word(parity_bias));
            else
                send_action(pick_removal(), $urandom);
        end
        gap_pct = 17;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = swpr_pkg::ACT_PUSH;
        i_push_value = '0;
        shadow_fill  = 0;
        failures     = 0;
        cycle_count  = 0;
        gap_pct      = 17;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_stack();
        test_parity_removal();
        test_fill_and_drain(0);
        test_random_mix(480);
        test_fill_and_drain($urandom_range(1, 2));

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (failures == 0 && expected_views.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
